### rtl/assert_macros.svh
// Assertion macros for the sum tree sampler RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under a synchronous reset.
`define WSST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous reset.
`define WSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define WSST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define WSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/wsst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted sampler sum tree.
// No dependencies; used by wsst_node_ram and weighted_sampler_sum_tree.
package wsst_pkg;

   localparam int NUM_LEAVES = 32;
   localparam int LEVELS     = $clog2(NUM_LEAVES);
   localparam int NODE_BITS  = LEVELS + 1;
   localparam int NODES      = 2 * NUM_LEAVES;

   localparam int COUNT_BITS  = 16;
   localparam int SUM_BITS    = 21;
   localparam int DELTA_BITS  = 17;
   localparam int DRAW_BITS   = 21;
   localparam int DEST_BITS   = 5;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 3;
   localparam int ACT_BITS    = 6;

   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 48;

   // Signed width that holds a count plus or minus a delta.
   localparam int CALC_BITS = ((COUNT_BITS > DELTA_BITS) ? COUNT_BITS : DELTA_BITS) + 2;

   localparam logic [ACT_BITS-1:0]  ACT_RESET = ACT_BITS'(32);
   localparam logic [CALC_BITS-1:0] COUNT_MAX = CALC_BITS'({COUNT_BITS{1'b1}});

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BAD_DEST = 3'd2,
      ST_RANGE    = 3'd3,
      ST_DRAW     = 3'd4
   } status_type;

   // Access request from the sequencer to the node memory.
   typedef struct packed {
      logic                 wr_en;
      logic [NODE_BITS-1:0] wr_addr;
      logic [SUM_BITS-1:0]  wr_data;
      logic [NODE_BITS-1:0] rd_addr;
   } ram_req_type;

endpackage

### rtl/weighted_sampler_sum_tree.sv
`timescale 1ns / 1ps
// Weighted sampler on a binary sum tree; one item in flight, one tree level per cycle, paced
// by the node memory's single registered read port. A bad destination, empty tree or draw too
// large ends at the lookup; a read or an out-of-range add ends after the leaf read; an add,
// clear or sample also walks the tree. The next item is taken once the result is registered,
// and a result still waiting on rsp holds the item behind it. Synchronous active-high reset:
// tree reads as all zero, active_outputs returns to 32. Uses wsst_pkg, wsst_node_ram, macros.
`include "assert_macros.svh"

module weighted_sampler_sum_tree (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wsst_pkg::REQ_DATA_BITS-1:0] req_tdata,  // dest[4:0], delta[21:5], draw[42:22]
   input  logic [wsst_pkg::OP_BITS-1:0]       req_tuser,  // op[1:0]
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wsst_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // chosen[4:0], leaf[20:5], total[41:21]
   output logic [wsst_pkg::STATUS_BITS-1:0]   rsp_tuser,  // status[2:0]
   // configuration: active_outputs
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wsst_pkg::ACT_BITS-1:0]      csr_data
);

   localparam int NB  = wsst_pkg::NODE_BITS;
   localparam int SB  = wsst_pkg::SUM_BITS;
   localparam int CB  = wsst_pkg::COUNT_BITS;
   localparam int XB  = wsst_pkg::CALC_BITS;
   localparam int PAD = wsst_pkg::RSP_DATA_BITS - SB - CB - wsst_pkg::DEST_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_EVAL,
      S_UPDATE,
      S_WALK,
      S_LEAF,
      S_DONE
   } state_type;

   state_type                            state_ff, state_in;
   wsst_pkg::op_type                     op_ff, op_in;
   logic [wsst_pkg::DEST_BITS-1:0]       dest_ff, dest_in;
   logic signed [wsst_pkg::DELTA_BITS-1:0] delta_ff, delta_in;
   logic [wsst_pkg::DRAW_BITS-1:0]       draw_ff, draw_in;
   logic [wsst_pkg::ACT_BITS-1:0]        active_ff, active_in;
   logic [SB-1:0]                        total_ff, total_in;
   logic [NB-1:0]                        node_ff, node_in;
   logic [SB-1:0]                        rest_ff, rest_in;
   logic [SB-1:0]                        diff_ff, diff_in;
   wsst_pkg::status_type                 status_ff, status_in;
   logic [CB-1:0]                        leaf_ff, leaf_in;
   logic [wsst_pkg::DEST_BITS-1:0]       chosen_ff, chosen_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [wsst_pkg::RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic [wsst_pkg::STATUS_BITS-1:0]     rsp_user_ff, rsp_user_in;

   wsst_pkg::ram_req_type                ram_req;
   logic [SB-1:0]                        rd_data;

   logic                                 req_take;
   logic                                 dest_bad;
   logic [NB-1:0]                        leaf_addr;
   logic [CB-1:0]                        cur;
   logic signed [XB-1:0]                 cur_s;
   logic signed [XB-1:0]                 next_s;
   logic signed [XB-1:0]                 new_s;
   logic                                 out_of_range;
   logic                                 go_right;
   logic [NB-1:0]                        walk_node;
   logic [NB-1:0]                        parent;

   wsst_node_ram u_node_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Reject a dest at or beyond active_outputs, or beyond the tree itself.
   assign dest_bad  = ({1'b0, dest_ff} >= active_ff) || (32'(dest_ff) >= wsst_pkg::NUM_LEAVES);
   assign leaf_addr = NB'(wsst_pkg::NUM_LEAVES) + NB'(dest_ff);

   // Leaf arithmetic for add and clear.
   assign cur          = rd_data[CB-1:0];
   assign cur_s        = $signed({{(XB - CB){1'b0}}, cur});
   assign next_s       = cur_s + XB'(delta_ff);
   assign out_of_range = next_s[XB-1] || (next_s > $signed(wsst_pkg::COUNT_MAX));
   assign new_s        = (op_ff == wsst_pkg::OP_ADD) ? next_s : '0;

   // Walk step: rd_data holds the left child of node_ff.
   assign go_right  = (rest_ff >= rd_data);
   assign walk_node = {node_ff[NB-2:0], go_right};
   assign parent    = node_ff >> 1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dest_in      = dest_ff;
      delta_in     = delta_ff;
      draw_in      = draw_ff;
      active_in    = active_ff;
      total_in     = total_ff;
      node_in      = node_ff;
      rest_in      = rest_ff;
      diff_in      = diff_ff;
      status_in    = status_ff;
      leaf_in      = leaf_ff;
      chosen_in    = chosen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_req      = '0;

      if (csr_valid && csr_ready) begin
         active_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in     = wsst_pkg::op_type'(req_tuser);
               dest_in   = req_tdata[4:0];
               delta_in  = req_tdata[21:5];
               draw_in   = req_tdata[42:22];
               status_in = wsst_pkg::ST_OK;
               leaf_in   = '0;
               chosen_in = '0;
               state_in  = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (op_ff == wsst_pkg::OP_SAMPLE) begin
               if (total_ff == '0) begin
                  status_in = wsst_pkg::ST_EMPTY;
                  state_in  = S_DONE;
               end else if (draw_ff >= total_ff) begin
                  status_in = wsst_pkg::ST_DRAW;
                  state_in  = S_DONE;
               end else begin
                  // fetch the root's left child and start the descent
                  node_in         = NB'(1);
                  rest_in         = draw_ff;
                  ram_req.rd_addr = NB'(2);
                  state_in        = S_WALK;
               end
            end else if (dest_bad) begin
               status_in = wsst_pkg::ST_BAD_DEST;
               state_in  = S_DONE;
            end else begin
               ram_req.rd_addr = leaf_addr;
               state_in        = S_EVAL;
            end
         end
         S_EVAL: begin
            if (op_ff == wsst_pkg::OP_READ) begin
               leaf_in  = cur;
               state_in = S_DONE;
            end else if ((op_ff == wsst_pkg::OP_ADD) && out_of_range) begin
               status_in = wsst_pkg::ST_RANGE;
               state_in  = S_DONE;
            end else begin
               // write the leaf, then carry the difference up through every ancestor
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = leaf_addr;
               ram_req.wr_data = SB'(new_s[CB-1:0]);
               ram_req.rd_addr = leaf_addr >> 1;
               leaf_in         = new_s[CB-1:0];
               diff_in         = SB'(new_s - cur_s);
               total_in        = total_ff + SB'(new_s - cur_s);
               node_in         = leaf_addr;
               state_in        = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = parent;
            ram_req.wr_data = rd_data + diff_ff;
            ram_req.rd_addr = node_ff >> 2;
            node_in         = parent;
            if (parent == NB'(1)) begin
               state_in = S_DONE;
            end
         end
         S_WALK: begin
            if (go_right) begin
               rest_in = rest_ff - rd_data;
            end
            node_in = walk_node;
            if (walk_node[NB-1]) begin
               // landed on a leaf: fetch its count
               ram_req.rd_addr = walk_node;
               state_in        = S_LEAF;
            end else begin
               ram_req.rd_addr = {walk_node[NB-2:0], 1'b0};
            end
         end
         S_LEAF: begin
            leaf_in   = rd_data[CB-1:0];
            chosen_in = wsst_pkg::DEST_BITS'(node_ff[NB-2:0]);
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD{1'b0}}, total_ff, leaf_ff, chosen_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= wsst_pkg::ACT_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      dest_ff     <= dest_in;
      delta_ff    <= delta_in;
      draw_ff     <= draw_in;
      node_ff     <= node_in;
      rest_ff     <= rest_in;
      diff_ff     <= diff_in;
      status_ff   <= status_in;
      leaf_ff     <= leaf_in;
      chosen_ff   <= chosen_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // A failed item reports neither a chosen output nor a count.
   `WSST_ASSERT_IMPLY(a_fail_zero, clock, reset,
      rsp_valid_ff && (rsp_user_ff != wsst_pkg::ST_OK), rsp_data_ff[20:0] == '0,
      "failed item carries nonzero leaf or chosen output")

   // A descent steered by a draw below the total lands on a leaf with a nonzero count.
   `WSST_ASSERT_NEXT(a_walk_nonzero, clock, reset, state_ff == S_LEAF, leaf_ff != '0,
      "sample landed on an empty leaf")

   // The ancestor update never runs past the root.
   `WSST_ASSERT_IMPLY(a_update_above_root, clock, reset, state_ff == S_UPDATE, node_ff > NB'(1),
      "ancestor update ran past the root")

endmodule

### rtl/wsst_node_ram.sv
`timescale 1ns / 1ps
// Node memory of the sum tree: one write port, one registered read port.
// Per-entry valid bits make unwritten nodes read as zero after reset. Uses wsst_pkg.
module wsst_node_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  wsst_pkg::ram_req_type         ram_req,
   output logic [wsst_pkg::SUM_BITS-1:0] rd_data
);

   logic [wsst_pkg::SUM_BITS-1:0] mem_ff [wsst_pkg::NODES];
   logic [wsst_pkg::NODES-1:0]    valid_ff;
   logic [wsst_pkg::SUM_BITS-1:0] rd_raw_ff;
   logic                          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_raw_ff <= mem_ff[ram_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            valid_ff[ram_req.wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[ram_req.rd_addr];
      end
   end

   // A node never written since reset holds zero.
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule
